// ----- sv/ttip_pkg.sv -----
// ----------------------------------------------------------------------------
// ttip_pkg - shared types, constants and helpers of the text-to-integer parser
// Character codes, parse phase codes, the classified character record and
// the classifier used by the front stage.
// ----------------------------------------------------------------------------
package ttip_pkg;

  // default sizes
  localparam int OFFSET_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 64;
  localparam int VALUE_W         = 64;
  localparam int CH_W            = 8;
  localparam int RADIX_W         = 6;
  localparam int QUEUE_DEPTH     = 2;

  // character codes
  localparam logic [CH_W-1:0] CHR_0     = 8'h30;
  localparam logic [CH_W-1:0] CHR_9     = 8'h39;
  localparam logic [CH_W-1:0] CHR_LA    = 8'h61;
  localparam logic [CH_W-1:0] CHR_LZ    = 8'h7a;
  localparam logic [CH_W-1:0] CHR_UA    = 8'h41;
  localparam logic [CH_W-1:0] CHR_UZ    = 8'h5a;
  localparam logic [CH_W-1:0] CHR_LX    = 8'h78;
  localparam logic [CH_W-1:0] CHR_UX    = 8'h58;
  localparam logic [CH_W-1:0] CHR_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CHR_PLUS  = 8'h2b;
  localparam logic [CH_W-1:0] CHR_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CHR_LF    = 8'h0a;
  localparam logic [CH_W-1:0] CHR_CR    = 8'h0d;
  localparam logic [CH_W-1:0] CHR_SPACE = 8'h20;

  // bases
  localparam logic [RADIX_W-1:0] BASE_DETECT = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;

  // worth of a non-alphanumeric character, never below any base
  localparam logic [RADIX_W-1:0] WORTH_NONE  = 6'd63;

  // parse phases
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PH_W-1:0] PH_WS     = 3'd1;
  localparam logic [PH_W-1:0] PH_PREFIX = 3'd2;
  localparam logic [PH_W-1:0] PH_AFTER0 = 3'd3;
  localparam logic [PH_W-1:0] PH_DIGITS = 3'd4;

  // one classified character
  typedef struct packed {
    logic [RADIX_W-1:0] worth;
    logic               is_blank;
    logic               is_minus;
    logic               is_plus;
    logic               is_zero;
    logic               is_x;
    logic               first;
    logic               last;
    logic [RADIX_W-1:0] radix;
  } item_t;

  function automatic logic [RADIX_W-1:0] char_worth(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] d;
    begin
      d = '0;
      if (c >= CHR_0 && c <= CHR_9) begin
        d = c - CHR_0;
      end else if (c >= CHR_LA && c <= CHR_LZ) begin
        d = c - CHR_LA + 8'd10;
      end else if (c >= CHR_UA && c <= CHR_UZ) begin
        d = c - CHR_UA + 8'd10;
      end else begin
        d = {2'b00, WORTH_NONE};
      end
      return d[RADIX_W-1:0];
    end
  endfunction

  function automatic item_t classify(input logic [CH_W-1:0] c,
                                     input logic [RADIX_W-1:0] radix,
                                     input logic first,
                                     input logic last);
    item_t it;
    begin
      it.worth    = char_worth(c);
      it.is_blank = (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) || (c == CHR_CR);
      it.is_minus = (c == CHR_MINUS);
      it.is_plus  = (c == CHR_PLUS);
      it.is_zero  = (c == CHR_0);
      it.is_x     = (c == CHR_LX) || (c == CHR_UX);
      it.first    = first;
      it.last     = last;
      it.radix    = radix;
      return it;
    end
  endfunction

endpackage

// ----- sv/ttip_text_if.sv -----
// ----------------------------------------------------------------------------
// ttip_text_if - character request channel
// Valid/ready channel carrying one text byte with its string markers.
// ----------------------------------------------------------------------------
interface ttip_text_if;
  import ttip_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    ch;
  logic [RADIX_W-1:0] radix;
  logic               first;
  logic               last;

  modport source(output valid, output ch, output radix, output first, output last,
                 input ready);
  modport sink(input valid, input ch, input radix, input first, input last,
               output ready);
endinterface

// ----- sv/ttip_result_if.sv -----
// ----------------------------------------------------------------------------
// ttip_result_if - parse result channel
// Valid/ready channel carrying the parsed value and the consumed count.
// ----------------------------------------------------------------------------
interface ttip_result_if #(
  parameter int OFFSET_BITS = ttip_pkg::OFFSET_BITS_DEF
);
  import ttip_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [OFFSET_BITS-1:0]    end_offset;

  modport source(output valid, output value, output end_offset, input ready);
  modport sink(input valid, input value, input end_offset, output ready);
endinterface

// ----- sv/ttip_front.sv -----
// ----------------------------------------------------------------------------
// ttip_front - character intake and classification
// Takes one byte per cycle unless a held byte waits on a full queue,
// classifies it and holds it in a register until the queue takes it.
// ----------------------------------------------------------------------------
module ttip_front (
  input  logic           clk,
  input  logic           rst,
  ttip_text_if.sink      text,
  output ttip_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_ready
);
  import ttip_pkg::*;

  logic  held;
  item_t held_item;

  // take a new request whenever the stage is empty or draining
  assign text.ready = !held || item_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (text.valid && text.ready) begin
      held <= 1'b1;
    end else if (item_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      held_item <= classify(text.ch, text.radix, text.first, text.last);
    end
  end

  assign item       = held_item;
  assign item_valid = held;
endmodule

// ----- sv/ttip_queue.sv -----
// ----------------------------------------------------------------------------
// ttip_queue - short queue of classified characters
// Register FIFO between the front and back stages so each can stall alone.
// ----------------------------------------------------------------------------
module ttip_queue #(
  parameter int DEPTH = ttip_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  ttip_pkg::item_t wr_item,
  input  logic            wr_valid,
  output logic            wr_ready,
  output ttip_pkg::item_t rd_item,
  output logic            rd_valid,
  input  logic            rd_ready
);
  import ttip_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end
endmodule

// ----- sv/ttip_back.sv -----
// ----------------------------------------------------------------------------
// ttip_back - parse state machine and accumulator
// Steps whitespace, sign, prefix and digits one character per cycle while no
// result waits unread, and holds each finished result in an output register.
// ----------------------------------------------------------------------------
module ttip_back #(
  parameter int OFFSET_BITS = ttip_pkg::OFFSET_BITS_DEF,
  parameter int VALUE_BITS  = ttip_pkg::VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ttip_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_ready,
  ttip_result_if.source   result
);
  import ttip_pkg::*;

  // parse state
  logic [PH_W-1:0]        phase;
  logic                   negative;
  logic [RADIX_W-1:0]     active_base;
  logic [VALUE_BITS-1:0]  acc;
  logic [OFFSET_BITS-1:0] consumed;

  // output register
  logic                   out_valid;
  logic                   out_neg;
  logic [VALUE_BITS-1:0]  out_acc;
  logic [OFFSET_BITS-1:0] out_cnt;

  // step results
  logic [PH_W-1:0]        phase_next;
  logic                   negative_next;
  logic [RADIX_W-1:0]     base_next;
  logic [VALUE_BITS-1:0]  acc_start;
  logic [VALUE_BITS-1:0]  acc_prod;
  logic [VALUE_BITS-1:0]  acc_next;
  logic [OFFSET_BITS-1:0] cnt_start;
  logic [OFFSET_BITS-1:0] consumed_next;
  logic                   take;
  logic                   stop;
  logic                   digit;
  logic                   done;
  logic                   pop;
  logic [VALUE_BITS-1:0]  signed_mag;

  assign item_ready = !out_valid || result.ready;
  assign pop        = item_valid && item_ready;

  // one character step
  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    base_next     = active_base;
    acc_start     = acc;
    cnt_start     = consumed;
    take          = 1'b0;
    stop          = 1'b0;
    digit         = 1'b0;

    // new string restarts everything
    if (item.first) begin
      phase_next    = PH_WS;
      negative_next = 1'b0;
      base_next     = item.radix;
      acc_start     = '0;
      cnt_start     = '0;
    end

    // leading blanks and sign
    if (phase_next == PH_WS) begin
      if (item.is_blank) begin
        take = 1'b1;
      end else if (item.is_minus) begin
        negative_next = 1'b1;
        take          = 1'b1;
        phase_next    = PH_PREFIX;
      end else if (item.is_plus) begin
        take       = 1'b1;
        phase_next = PH_PREFIX;
      end else begin
        phase_next = PH_PREFIX;
      end
    end

    // base detection and leading zero
    if (!take && phase_next == PH_PREFIX) begin
      if (base_next == BASE_DETECT) begin
        if (item.is_zero) begin
          take       = 1'b1;
          base_next  = BASE_OCT;
          phase_next = PH_AFTER0;
        end else begin
          base_next  = BASE_DEC;
          phase_next = PH_DIGITS;
        end
      end else if (base_next == BASE_HEX && item.is_zero) begin
        take       = 1'b1;
        phase_next = PH_AFTER0;
      end else begin
        phase_next = PH_DIGITS;
      end
    end

    // optional x after the zero
    if (!take && phase_next == PH_AFTER0) begin
      phase_next = PH_DIGITS;
      if (item.is_x) begin
        take      = 1'b1;
        base_next = BASE_HEX;
      end
    end

    // digits
    if (!take && phase_next == PH_DIGITS) begin
      if (item.worth < base_next) begin
        digit = 1'b1;
        take  = 1'b1;
      end else begin
        stop = 1'b1;
      end
    end

    done = stop || (take && item.last);
    if (done) begin
      phase_next = PH_IDLE;
    end
  end

  // multiply-add, wrapping
  assign acc_prod = acc_start * VALUE_BITS'(base_next);
  assign acc_next = digit ? acc_prod + VALUE_BITS'(item.worth) : acc_start;

  // saturating consumed count
  assign consumed_next = (take && cnt_start != '1) ? cnt_start + 1'b1 : cnt_start;

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      negative    <= 1'b0;
      active_base <= '0;
      acc         <= '0;
      consumed    <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      negative    <= negative_next;
      active_base <= base_next;
      acc         <= acc_next;
      consumed    <= consumed_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && done) begin
      out_neg <= negative_next;
      out_acc <= acc_next;
      out_cnt <= consumed_next;
    end
  end

  // apply sign and widen
  assign signed_mag        = out_neg ? VALUE_BITS'(-out_acc) : out_acc;
  assign result.valid      = out_valid;
  assign result.value      = VALUE_W'(signed'(signed_mag));
  assign result.end_offset = out_cnt;
endmodule

// ----- sv/text_to_integer_parser_top.sv -----
// ----------------------------------------------------------------------------
// text_to_integer_parser_top - streaming text to signed integer converter
// Front classifier, short queue and back parser with an output register.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle, sustained, as long as results are
// taken. A character passes the classify register, the two-entry queue and
// the parse step. When it ends the string, the parse step writes its result
// to the output register. While a finished result waits on the output the
// parse step stalls. Up to three more characters are then taken, one in the
// classify register and two in the queue, before the input stalls. The rate
// is set by the parse step in the back stage, a loop through the VALUE_BITS
// by 6 bit multiply-add of the accumulator register. Each string gives at
// most one result, as a new first character restarts an open string;
// characters outside a string are dropped.
module text_to_integer_parser_top #(
  parameter int OFFSET_BITS = ttip_pkg::OFFSET_BITS_DEF,
  parameter int VALUE_BITS  = ttip_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ttip_text_if.sink     text,
  ttip_result_if.source result
);
  import ttip_pkg::*;

  item_t front_item;
  logic  front_valid;
  logic  front_ready;
  item_t queue_item;
  logic  queue_valid;
  logic  queue_ready;

  // intake and classification
  ttip_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  // decoupling queue
  ttip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (front_item),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_item  (queue_item),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready)
  );

  // parser and result register
  ttip_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (queue_item),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .result     (result)
  );
endmodule

// ----- sv/ttip_checker.sv -----
// ----------------------------------------------------------------------------
// ttip_checker - port-level checks of the text-to-integer parser
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module ttip_checker #(
  parameter int OFFSET_BITS = ttip_pkg::OFFSET_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ttip_pkg::VALUE_W-1:0] out_value,
  input logic [OFFSET_BITS-1:0]            out_end_offset
);
  import ttip_pkg::*;

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_end_offset))
    else $error("stalled result changed");

  // nothing comes out straight after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // a non-zero value needs consumed characters
  a_value_needs_chars: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_value != '0 |-> out_end_offset != '0)
    else $error("non-zero value with no characters consumed");
endmodule

bind text_to_integer_parser_top ttip_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_ttip_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_value      (result.value),
  .out_end_offset (result.end_offset)
);

// ----- verif/text_to_integer_parser_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_to_integer_parser_top_tb - self-checking bench for the text parser
// A table of directed character requests is followed by random strings under
// four idling patterns. Every accepted character goes through a behavioural
// parser in the bench. The value and consumed count it works out, or those a
// directed row gives, are queued and checked against each result the block returns.
// ----------------------------------------------------------------------------
module text_to_integer_parser_top_tb;
  import ttip_pkg::*;

  localparam int OFF_W        = OFFSET_BITS_DEF;
  localparam int STUCK_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 360;
  localparam int SETTLE       = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int LONG_DIGITS  = 40;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [RADIX_W-1:0] radix;
    logic               first;
    logic               last;
  } text_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [OFF_W-1:0]          end_offset;
  } parse_result_t;

  typedef struct packed {
    text_req_t     req;
    logic          typed;
    parse_result_t res;
  } dir_row_t;

  logic clk;
  logic rst;

  ttip_text_if                                  text_ch();
  ttip_result_if #(.OFFSET_BITS(OFFSET_BITS_DEF)) res_ch();

  text_to_integer_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch)
  );

  // parser state mirrored by the bench
  logic [PH_W-1:0]    parse_phase;
  logic               parse_neg;
  logic [RADIX_W-1:0] parse_base;
  logic [VALUE_W-1:0] parse_acc;
  logic [OFF_W-1:0]   parse_count;

  parse_result_t pending_results[$];
  int            mismatch_count;
  int            useful_items;
  int            send_idle_pct;
  int            stall_pct;
  int            hold_reqs;
  int            quiet_cycles;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // one parse step; returns 1 with the finished number when the string ends
  function automatic bit parse_char(input text_req_t rq, output parse_result_t res);
    int worth;
    bit take;
    bit stop;
    logic [CH_W-1:0] c;
    c = rq.ch;
    take = 1'b0;
    stop = 1'b0;
    res = '0;
    if (rq.first) begin
      parse_phase = PH_WS;
      parse_neg   = 1'b0;
      parse_base  = rq.radix;
      parse_acc   = '0;
      parse_count = '0;
    end
    if (parse_phase == PH_IDLE) return 1'b0;
    // leading blanks and sign
    if (parse_phase == PH_WS) begin
      if (c == CHR_SPACE || c == CHR_TAB || c == CHR_LF || c == CHR_CR) begin
        take = 1'b1;
      end else if (c == CHR_MINUS) begin
        parse_neg = 1'b1;
        take = 1'b1;
        parse_phase = PH_PREFIX;
      end else if (c == CHR_PLUS) begin
        take = 1'b1;
        parse_phase = PH_PREFIX;
      end else begin
        parse_phase = PH_PREFIX;
      end
    end
    // base prefix
    if (!take && parse_phase == PH_PREFIX) begin
      if (parse_base == BASE_DETECT) begin
        if (c == CHR_0) begin
          take = 1'b1;
          parse_base = BASE_OCT;
          parse_phase = PH_AFTER0;
        end else begin
          parse_base = BASE_DEC;
          parse_phase = PH_DIGITS;
        end
      end else if (parse_base == BASE_HEX && c == CHR_0) begin
        take = 1'b1;
        parse_phase = PH_AFTER0;
      end else begin
        parse_phase = PH_DIGITS;
      end
    end
    if (!take && parse_phase == PH_AFTER0) begin
      parse_phase = PH_DIGITS;
      if (c == CHR_LX || c == CHR_UX) begin
        take = 1'b1;
        parse_base = BASE_HEX;
      end
    end
    // digits
    if (!take && parse_phase == PH_DIGITS) begin
      if (c >= CHR_0 && c <= CHR_9) worth = int'(c - CHR_0);
      else if (c >= CHR_LA && c <= CHR_LZ) worth = int'(c - CHR_LA) + 10;
      else if (c >= CHR_UA && c <= CHR_UZ) worth = int'(c - CHR_UA) + 10;
      else worth = 99;
      if (worth < int'(parse_base)) begin
        parse_acc = parse_acc * VALUE_W'(parse_base) + VALUE_W'(worth);
        take = 1'b1;
      end else begin
        stop = 1'b1;
      end
    end
    if (take && parse_count != '1) parse_count = parse_count + 1'b1;
    if (stop || (take && rq.last)) begin
      res.value      = parse_neg ? -parse_acc : parse_acc;
      res.end_offset = parse_count;
      parse_phase    = PH_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic text_req_t mk(input logic [CH_W-1:0] c, input logic [RADIX_W-1:0] r,
                                   input logic f, input logic l);
    text_req_t rq;
    rq.ch = c;
    rq.radix = r;
    rq.first = f;
    rq.last = l;
    return rq;
  endfunction

  function automatic dir_row_t row(input text_req_t rq, input logic typed,
                                   input logic signed [VALUE_W-1:0] v,
                                   input logic [OFF_W-1:0] o);
    dir_row_t d;
    d.req = rq;
    d.typed = typed;
    d.res.value = v;
    d.res.end_offset = o;
    return d;
  endfunction

  // present one character request, wait for it to be taken, queue its result
  task automatic send_req(input text_req_t rq, input logic typed, input parse_result_t typed_res);
    parse_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.ch    <= rq.ch;
    text_ch.radix <= rq.radix;
    text_ch.first <= rq.first;
    text_ch.last  <= rq.last;
    do @(posedge clk); while (!text_ch.ready);
    if (rq.first || parse_phase != PH_IDLE) useful_items++;
    if (parse_char(rq, got)) pending_results.push_back(typed ? typed_res : got);
    @(negedge clk);
  endtask

  // stop offering requests until every queued result has come back
  task automatic drain_results();
    text_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CH_W-1:0] digit_char(input int v);
    if (v < 10) return CHR_0 + CH_W'(v);
    return ($urandom_range(1) != 0) ? CHR_LA + CH_W'(v - 10) : CHR_UA + CH_W'(v - 10);
  endfunction

  // one random string, mostly well formed, sometimes plain noise
  task automatic send_random_string();
    text_req_t          s[$];
    logic [RADIX_W-1:0] r;
    int                 eff;
    int                 n;
    int                 k;
    logic [CH_W-1:0]    c;
    parse_result_t      none_res;
    none_res = '0;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(mk(CH_W'($urandom_range(255)), RADIX_W'($urandom_range(63)),
                                $urandom_range(7) == 0, $urandom_range(3) == 0));
    end else begin
      case ($urandom_range(9))
        0, 1: r = BASE_DETECT;
        2: r = BASE_OCT;
        3, 4: r = BASE_DEC;
        5, 6: r = BASE_HEX;
        7: r = 6'd2;
        8: r = 6'd36;
        default: r = RADIX_W'($urandom_range(63));
      endcase
      eff = int'(r);
      // leading blanks
      repeat ($urandom_range(2)) begin
        case ($urandom_range(3))
          0: c = CHR_SPACE;
          1: c = CHR_TAB;
          2: c = CHR_LF;
          default: c = CHR_CR;
        endcase
        s.push_back(mk(c, 0, 0, 0));
      end
      // sign
      k = $urandom_range(3);
      if (k == 0) s.push_back(mk(CHR_MINUS, 0, 0, 0));
      else if (k == 1) s.push_back(mk(CHR_PLUS, 0, 0, 0));
      // prefix
      if (r == BASE_DETECT) begin
        k = $urandom_range(2);
        eff = int'(BASE_DEC);
        if (k >= 1) begin
          s.push_back(mk(CHR_0, 0, 0, 0));
          eff = int'(BASE_OCT);
        end
        if (k == 2) begin
          s.push_back(mk(($urandom_range(1) != 0) ? CHR_LX : CHR_UX, 0, 0, 0));
          eff = int'(BASE_HEX);
        end
      end else if (r == BASE_HEX && $urandom_range(1) != 0) begin
        s.push_back(mk(CHR_0, 0, 0, 0));
        if ($urandom_range(2) != 0)
          s.push_back(mk(($urandom_range(1) != 0) ? CHR_LX : CHR_UX, 0, 0, 0));
      end
      // digits, a few long runs to make the value wrap
      n = ($urandom_range(15) == 0) ? $urandom_range(14, 30) : $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(19) < 17 && eff > 0)
          c = digit_char($urandom_range(((eff > 36) ? 36 : eff) - 1));
        else
          c = CH_W'($urandom_range(255));
        s.push_back(mk(c, 0, 0, 0));
      end
      // ending: last flag, a stopping character, or anything
      case ($urandom_range(2))
        0: begin
          if (s.size() == 0) s.push_back(mk(CH_W'($urandom_range(255)), 0, 0, 1));
          else s[s.size()-1].last = 1'b1;
        end
        1: begin
          case ($urandom_range(4))
            0: c = 8'h00;
            1: c = CHR_SPACE;
            2: c = CHR_MINUS;
            3: c = 8'hff;
            default: c = 8'h3b;
          endcase
          s.push_back(mk(c, 0, 0, 1'($urandom_range(1))));
        end
        default: s.push_back(mk(CH_W'($urandom_range(255)), 0, 0, 1'($urandom_range(1))));
      endcase
      // radix is only sampled with first, so the others carry junk
      foreach (s[i]) s[i].radix = RADIX_W'($urandom_range(63));
      s[0].first = 1'b1;
      s[0].radix = r;
    end
    foreach (s[i]) send_req(s[i], 1'b0, none_res);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: value %0d end_offset %0d",
                     res_ch.value, res_ch.end_offset);
        end else begin
          want = pending_results.pop_front();
          if (res_ch.value !== want.value || res_ch.end_offset !== want.end_offset) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("bad result: value %0d (exp %0d) end_offset %0d (exp %0d)",
                       res_ch.value, want.value, res_ch.end_offset, want.end_offset);
          end
        end
      end
      if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STUCK_LIMIT) begin
        $display("text_to_integer_parser_top: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    dir_row_t      directed_rows[];
    parse_result_t none_res;
    int            pressure_at;
    none_res       = '0;
    mismatch_count = 0;
    useful_items   = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_reqs      = 0;
    quiet_cycles   = 0;
    parse_phase    = PH_IDLE;
    parse_neg      = 1'b0;
    parse_base     = '0;
    parse_acc      = '0;
    parse_count    = '0;
    rst            = 1'b1;
    text_ch.valid  = 1'b0;
    text_ch.ch     = '0;
    text_ch.radix  = '0;
    text_ch.first  = 1'b0;
    text_ch.last   = 1'b0;

    directed_rows = '{
      // ignored while no string is open
      row(mk("x", 6'd10, 0, 0), 0, 0, 0),
      // blanks, minus, hex prefix with base 16, ends on last
      row(mk(CHR_SPACE, BASE_HEX, 1, 0), 0, 0, 0),
      row(mk(CHR_TAB, 6'd0, 0, 0), 0, 0, 0),
      row(mk(CHR_MINUS, 6'd0, 0, 0), 0, 0, 0),
      row(mk(CHR_0, 6'd0, 0, 0), 0, 0, 0),
      row(mk(CHR_UX, 6'd0, 0, 0), 0, 0, 0),
      row(mk("f", 6'd0, 0, 0), 0, 0, 0),
      row(mk("F", 6'd0, 0, 1), 1, -64'sd255, 16'd7),
      // bare 0x with detection, closed by a zero byte: prefix still counts
      row(mk(CHR_0, BASE_DETECT, 1, 0), 0, 0, 0),
      row(mk(CHR_LX, 6'd63, 0, 0), 0, 0, 0),
      row(mk(8'h00, 6'd0, 0, 0), 1, 64'sd0, 16'd2),
      // zero after base 16 start is taken as the prefix zero, then 7 is a digit
      row(mk(CHR_0, BASE_HEX, 1, 0), 0, 0, 0),
      row(mk("7", 6'd0, 0, 1), 1, 64'sd7, 16'd2),
      // base 1 takes only zero
      row(mk(CHR_0, 6'd1, 1, 0), 0, 0, 0),
      row(mk("1", 6'd1, 0, 0), 1, 64'sd0, 16'd1),
      // widest base, first and last together
      row(mk(CHR_LZ, 6'd63, 1, 1), 1, 64'sd35, 16'd1),
      // restart mid-string, stopper on a last item is not counted
      row(mk("5", BASE_DEC, 1, 0), 0, 0, 0),
      row(mk(CHR_PLUS, 6'd36, 1, 0), 0, 0, 0),
      row(mk(CHR_UZ, 6'd0, 0, 0), 0, 0, 0),
      row(mk(CHR_CR, 6'd0, 0, 1), 1, 64'sd35, 16'd2),
      // top byte stops at once
      row(mk(8'hff, 6'd63, 1, 1), 1, 64'sd0, 16'd0),
      // line feed as a blank
      row(mk(CHR_LF, BASE_DEC, 1, 0), 0, 0, 0),
      row(mk(CHR_9, BASE_DEC, 0, 1), 1, 64'sd9, 16'd2)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_req(directed_rows[i].req, directed_rows[i].typed,
                                        directed_rows[i].res);

    // a long decimal string so the value wraps
    send_req(mk("1", BASE_DEC, 1, 0), 1'b0, none_res);
    repeat (LONG_DIGITS) send_req(mk(CHR_9, RADIX_W'($urandom_range(63)), 0, 0), 1'b0,
                                  none_res);
    send_req(mk(8'h3b, 6'd0, 0, 0), 1'b0, none_res);
    drain_results();

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      useful_items = 0;
      pressure_at = PHASE_ITEMS / 2;
      while (useful_items < PHASE_ITEMS) begin
        // back-pressure burst: receiver holds off while one-digit strings pile up
        if (ph == 0 && useful_items >= pressure_at) begin
          pressure_at = PHASE_ITEMS * 2;
          hold_reqs++;
          repeat (40) send_req(mk(digit_char($urandom_range(9)), BASE_DEC, 1, 1),
                               1'b0, none_res);
          drain_results();
        end
        send_random_string();
      end
    end

    text_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_to_integer_parser_top: match");
    end else begin
      $display("text_to_integer_parser_top: mismatch");
    end
    $finish;
  end

endmodule
